// File: design/p2r_pkg.sv
// ----------------------------------------------------------------------------
// p2r_pkg
// shared constants and types of the pixel to rgb888 converter
// ----------------------------------------------------------------------------
package p2r_pkg;

  localparam int SAMPLE_W = 16;
  localparam int CC_W     = 3;
  localparam int CHAN_W   = 8;
  localparam int NCH      = 3;
  localparam int QUO_W    = CHAN_W;

  // products and long-division operands
  localparam int PROD_W = 2 * SAMPLE_W;        // channel * black, max^2
  localparam int SCL_W  = SAMPLE_W + CHAN_W;   // sample * 255
  localparam int DEN_W  = PROD_W + 1;          // 2 * max^2
  localparam int NUM_W  = DEN_W + QUO_W;       // 510 * p + q

  // pipeline: two front stages, one stage per quotient bit, output register
  localparam int NSTAGE = 2 + QUO_W + 1;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = SAMPLE_W;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FULL_SCALE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COMP_COUNT  = 1'd1;

  // component count codes
  localparam logic [CC_W-1:0] CC_GRAY = 3'd1;
  localparam logic [CC_W-1:0] CC_RGB  = 3'd3;
  localparam logic [CC_W-1:0] CC_CMYK = 3'd4;

  localparam logic [SAMPLE_W-1:0] FULL_SCALE_RST = 16'd255;
  localparam logic [CC_W-1:0]     COMP_COUNT_RST = CC_RGB;
  localparam logic [CHAN_W-1:0]   CHAN_FULL      = 8'd255;

  // one channel in flight through the divider
  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
    logic [QUO_W-1:0] quo;
    logic             sat;
  } chan_t;

  // per-item side information
  typedef struct packed {
    logic bad;
    logic row_end;
  } ctl_t;

endpackage

// File: design/p2r_in_if.sv
// ----------------------------------------------------------------------------
// p2r_in_if
// input channel: one decoded pixel of up to four samples
// ----------------------------------------------------------------------------
interface p2r_in_if;
  logic                          valid;
  logic                          ready;
  logic [p2r_pkg::SAMPLE_W-1:0]  sample_0;
  logic [p2r_pkg::SAMPLE_W-1:0]  sample_1;
  logic [p2r_pkg::SAMPLE_W-1:0]  sample_2;
  logic [p2r_pkg::SAMPLE_W-1:0]  sample_3;
  logic                          row_end_in;

  modport source (output valid, sample_0, sample_1, sample_2, sample_3, row_end_in,
                  input ready);
  modport sink   (input valid, sample_0, sample_1, sample_2, sample_3, row_end_in,
                  output ready);
endinterface

// File: design/p2r_out_if.sv
// ----------------------------------------------------------------------------
// p2r_out_if
// output channel: one 8-bit rgb pixel with status
// ----------------------------------------------------------------------------
interface p2r_out_if;
  logic                        valid;
  logic                        ready;
  logic [p2r_pkg::CHAN_W-1:0]  red;
  logic [p2r_pkg::CHAN_W-1:0]  green;
  logic [p2r_pkg::CHAN_W-1:0]  blue;
  logic                        bad_format;
  logic                        row_end_out;

  modport source (output valid, red, green, blue, bad_format, row_end_out,
                  input ready);
  modport sink   (input valid, red, green, blue, bad_format, row_end_out,
                  output ready);
endinterface

// File: design/p2r_front.sv
// ----------------------------------------------------------------------------
// p2r_front
// two stages: products and saturation, then dividend and divisor per channel
// ----------------------------------------------------------------------------
module p2r_front (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic [1:0]                             adv,
  input  logic                                   in_valid,
  input  logic [p2r_pkg::SAMPLE_W-1:0]           sample_0,
  input  logic [p2r_pkg::SAMPLE_W-1:0]           sample_1,
  input  logic [p2r_pkg::SAMPLE_W-1:0]           sample_2,
  input  logic [p2r_pkg::SAMPLE_W-1:0]           sample_3,
  input  logic                                   row_end_in,
  input  logic [p2r_pkg::SAMPLE_W-1:0]           full_scale,
  input  logic [p2r_pkg::CC_W-1:0]               component_count,
  output logic [1:0]                             vld,
  output p2r_pkg::chan_t [p2r_pkg::NCH-1:0]      out_ch,
  output p2r_pkg::ctl_t                          out_ctl
);

  logic [p2r_pkg::SAMPLE_W-1:0] ch [p2r_pkg::NCH];
  logic                         bad;
  logic                         gray;

  // stage 1 registers
  logic [p2r_pkg::PROD_W-1:0]   p1_prod [p2r_pkg::NCH];
  logic [p2r_pkg::SCL_W-1:0]    p1_scl  [p2r_pkg::NCH];
  logic [p2r_pkg::NCH-1:0]      p1_sat;
  logic [p2r_pkg::PROD_W-1:0]   p1_msq;
  logic [p2r_pkg::SAMPLE_W-1:0] p1_max;
  logic                         p1_cmyk;
  p2r_pkg::ctl_t                p1_ctl;

  p2r_pkg::chan_t [p2r_pkg::NCH-1:0] ch_next;

  always_comb begin
    bad  = (full_scale == '0) ||
           !(component_count inside {p2r_pkg::CC_GRAY, p2r_pkg::CC_RGB, p2r_pkg::CC_CMYK});
    gray = (component_count == p2r_pkg::CC_GRAY);
    // gray feeds sample_0 to all three channels
    ch[0] = sample_0;
    ch[1] = gray ? sample_0 : sample_1;
    ch[2] = gray ? sample_0 : sample_2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) begin
        vld[0] <= in_valid;
      end
      if (adv[1]) begin
        vld[1] <= vld[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      for (int c = 0; c < p2r_pkg::NCH; c++) begin
        p1_prod[c] <= p2r_pkg::PROD_W'(ch[c]) * p2r_pkg::PROD_W'(sample_3);
        // s * 255 as s * 256 - s
        p1_scl[c]  <= {ch[c], 8'd0} - p2r_pkg::SCL_W'(ch[c]);
        p1_sat[c]  <= (ch[c] >= full_scale);
      end
      p1_msq        <= p2r_pkg::PROD_W'(full_scale) * p2r_pkg::PROD_W'(full_scale);
      p1_max        <= full_scale;
      p1_cmyk       <= (component_count == p2r_pkg::CC_CMYK);
      p1_ctl.bad     <= bad;
      p1_ctl.row_end <= row_end_in;
    end
  end

  always_comb begin
    for (int c = 0; c < p2r_pkg::NCH; c++) begin
      ch_next[c].quo = '0;
      if (p1_cmyk) begin
        // (2*p*255 + q) / (2*q), saturate at p >= q; 510*p as 512*p - 2*p
        ch_next[c].num = {p1_prod[c], 9'd0} - p2r_pkg::NUM_W'({p1_prod[c], 1'b0})
                         + p2r_pkg::NUM_W'(p1_msq);
        ch_next[c].den = {p1_msq, 1'b0};
        ch_next[c].sat = (p1_prod[c] >= p1_msq);
      end else begin
        // (s*255 + max/2) / max, saturate at s >= max
        ch_next[c].num = p2r_pkg::NUM_W'(p1_scl[c]) + p2r_pkg::NUM_W'(p1_max[15:1]);
        ch_next[c].den = p2r_pkg::DEN_W'(p1_max);
        ch_next[c].sat = p1_sat[c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      out_ch  <= ch_next;
      out_ctl <= p1_ctl;
    end
  end

endmodule

// File: design/p2r_div_stage.sv
// ----------------------------------------------------------------------------
// p2r_div_stage
// one restoring long-division step for all channels, settles one quotient bit
// ----------------------------------------------------------------------------
module p2r_div_stage #(
  parameter int BIT = p2r_pkg::QUO_W - 1
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   adv,
  input  logic                                   in_valid,
  input  p2r_pkg::chan_t [p2r_pkg::NCH-1:0]      in_ch,
  input  p2r_pkg::ctl_t                          in_ctl,
  output logic                                   out_valid,
  output p2r_pkg::chan_t [p2r_pkg::NCH-1:0]      out_ch,
  output p2r_pkg::ctl_t                          out_ctl
);

  localparam int PAD_W = p2r_pkg::NUM_W - p2r_pkg::DEN_W;

  logic [p2r_pkg::NUM_W-1:0]         dshift [p2r_pkg::NCH];
  p2r_pkg::chan_t [p2r_pkg::NCH-1:0] ch_next;

  always_comb begin
    for (int c = 0; c < p2r_pkg::NCH; c++) begin
      dshift[c]  = {{PAD_W{1'b0}}, in_ch[c].den} << BIT;
      ch_next[c] = in_ch[c];
      if (in_ch[c].num >= dshift[c]) begin
        ch_next[c].num      = in_ch[c].num - dshift[c];
        ch_next[c].quo[BIT] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_ch  <= ch_next;
      out_ctl <= in_ctl;
    end
  end

endmodule

// File: design/pixel_to_rgb888_converter_top.sv
// ----------------------------------------------------------------------------
// pixel_to_rgb888_converter_top
// pipeline: 2 front stages, 8 divider stages at one quotient bit each, and
//   1 output register
// throughput: one item per clock while the output is ready; a stage advances when
//   empty or when the next one moves, so bubbles fill while the output stalls
// reset: synchronous rst empties the pipeline, full_scale goes to 255 and
//   component_count to 3 (rgb)
// ----------------------------------------------------------------------------
module pixel_to_rgb888_converter_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write_en,
  input  logic [p2r_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [p2r_pkg::CFG_DATA_W-1:0]    cfg_data,
  p2r_in_if.sink                            pix_in,
  p2r_out_if.source                         pix_out
);

  localparam int LAST = p2r_pkg::NSTAGE - 1;

  // configuration registers
  logic [p2r_pkg::SAMPLE_W-1:0] full_scale;
  logic [p2r_pkg::CC_W-1:0]     component_count;

  // stage valids and advance enables, index 0 is the first front stage
  logic [1:0]                   front_vld;
  logic [p2r_pkg::QUO_W-1:0]    div_vld;
  logic                         out_vld;
  logic [p2r_pkg::NSTAGE-1:0]   vld;
  logic [p2r_pkg::NSTAGE-1:0]   adv;

  // divider chain, entry 0 is the front output
  p2r_pkg::chan_t [p2r_pkg::NCH-1:0] dch  [p2r_pkg::QUO_W+1];
  p2r_pkg::ctl_t                     dctl [p2r_pkg::QUO_W+1];

  // output register payload
  logic [p2r_pkg::CHAN_W-1:0] rgb [p2r_pkg::NCH];
  logic                       bad_format;
  logic                       row_end_out;
  logic [p2r_pkg::CHAN_W-1:0] rgb_next [p2r_pkg::NCH];

  // config writes, expected only while the pipeline is empty
  always_ff @(posedge clk) begin
    if (rst) begin
      full_scale      <= p2r_pkg::FULL_SCALE_RST;
      component_count <= p2r_pkg::COMP_COUNT_RST;
    end else if (cfg_write_en) begin
      case (cfg_index)
        p2r_pkg::REG_FULL_SCALE: full_scale      <= cfg_data;
        p2r_pkg::REG_COMP_COUNT: component_count <= cfg_data[p2r_pkg::CC_W-1:0];
        default: ;
      endcase
    end
  end

  assign vld = {out_vld, div_vld, front_vld};

  // ready ripples back: a stage moves when it is empty or its successor moves
  always_comb begin
    adv[LAST] = !vld[LAST] || pix_out.ready;
    for (int k = LAST - 1; k >= 0; k--) begin
      adv[k] = !vld[k] || adv[k+1];
    end
  end

  assign pix_in.ready = adv[0];

  // products, saturation checks, dividend and divisor
  p2r_front u_front (
    .clk             (clk),
    .rst             (rst),
    .adv             (adv[1:0]),
    .in_valid        (pix_in.valid),
    .sample_0        (pix_in.sample_0),
    .sample_1        (pix_in.sample_1),
    .sample_2        (pix_in.sample_2),
    .sample_3        (pix_in.sample_3),
    .row_end_in      (pix_in.row_end_in),
    .full_scale      (full_scale),
    .component_count (component_count),
    .vld             (front_vld),
    .out_ch          (dch[0]),
    .out_ctl         (dctl[0])
  );

  // one quotient bit per stage, msb first
  for (genvar i = 0; i < p2r_pkg::QUO_W; i++) begin : g_div
    p2r_div_stage #(
      .BIT (p2r_pkg::QUO_W - 1 - i)
    ) u_div (
      .clk       (clk),
      .rst       (rst),
      .adv       (adv[2+i]),
      .in_valid  (vld[1+i]),
      .in_ch     (dch[i]),
      .in_ctl    (dctl[i]),
      .out_valid (div_vld[i]),
      .out_ch    (dch[i+1]),
      .out_ctl   (dctl[i+1])
    );
  end

  // bad format forces zero, saturation forces full scale
  always_comb begin
    for (int c = 0; c < p2r_pkg::NCH; c++) begin
      if (dctl[p2r_pkg::QUO_W].bad) begin
        rgb_next[c] = '0;
      end else if (dch[p2r_pkg::QUO_W][c].sat) begin
        rgb_next[c] = p2r_pkg::CHAN_FULL;
      end else begin
        rgb_next[c] = dch[p2r_pkg::QUO_W][c].quo;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (adv[LAST]) begin
      out_vld <= vld[LAST-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[LAST]) begin
      for (int c = 0; c < p2r_pkg::NCH; c++) begin
        rgb[c] <= rgb_next[c];
      end
      bad_format  <= dctl[p2r_pkg::QUO_W].bad;
      row_end_out <= dctl[p2r_pkg::QUO_W].row_end;
    end
  end

  assign pix_out.valid       = out_vld;
  assign pix_out.red         = rgb[0];
  assign pix_out.green       = rgb[1];
  assign pix_out.blue        = rgb[2];
  assign pix_out.bad_format  = bad_format;
  assign pix_out.row_end_out = row_end_out;

  // an accepted item always lands in the first stage
  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    pix_in.valid && pix_in.ready |=> front_vld[0])
    else $error("accepted item missing from first stage");

  // a bad-format result never carries channel data
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    pix_out.valid && pix_out.bad_format |->
      pix_out.red == '0 && pix_out.green == '0 && pix_out.blue == '0)
    else $error("bad format result with nonzero channels");

  // a front item blocked by the divider is held, not dropped
  a_front_hold: assert property (@(posedge clk) disable iff (rst)
    front_vld[1] && !adv[2] |=> front_vld[1] && $stable(dch[0]) && $stable(dctl[0]))
    else $error("stalled front item lost or changed");

  // a divider-output item blocked by the output register is held
  a_div_hold: assert property (@(posedge clk) disable iff (rst)
    vld[LAST-1] && !adv[LAST] |=> vld[LAST-1] && $stable(dch[p2r_pkg::QUO_W]))
    else $error("stalled divider item lost or changed");

endmodule

// File: sim/p2r_pixel_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// p2r_pixel_checker
// watches the config port and both pixel channels, predicts each rgb888
// result from the accepted input item and compares it with what comes out
// ----------------------------------------------------------------------------
module p2r_pixel_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write_en,
  input  logic [p2r_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [p2r_pkg::CFG_DATA_W-1:0] cfg_data,
  p2r_in_if                              pix_in,
  p2r_out_if                             pix_out,
  output int                             fail_count,
  output int                             pending
);

  typedef struct packed {
    logic [p2r_pkg::CHAN_W-1:0] red;
    logic [p2r_pkg::CHAN_W-1:0] green;
    logic [p2r_pkg::CHAN_W-1:0] blue;
    logic                       bad_format;
    logic                       row_end;
  } rgb_pixel_t;

  // shadow copies of the two registers
  logic [p2r_pkg::SAMPLE_W-1:0] full_scale;
  logic [p2r_pkg::CC_W-1:0]     comp_count;

  rgb_pixel_t pixels_due[$];
  rgb_pixel_t got_px;
  rgb_pixel_t want_px;

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    fail_count++;
  endtask

  // round(s * 255 / max), saturating at or above max
  function automatic logic [p2r_pkg::CHAN_W-1:0] scale_to_8bit(
      input logic [p2r_pkg::SAMPLE_W-1:0] s,
      input logic [p2r_pkg::SAMPLE_W-1:0] mx);
    logic [63:0] num;
    if (s >= mx) return p2r_pkg::CHAN_FULL;
    num = 64'(s) * 64'd255 + 64'(mx >> 1);
    return p2r_pkg::CHAN_W'(num / 64'(mx));
  endfunction

  // round(chan * black * 255 / max^2), ties up, clamped
  function automatic logic [p2r_pkg::CHAN_W-1:0] ink_to_8bit(
      input logic [p2r_pkg::SAMPLE_W-1:0] chan,
      input logic [p2r_pkg::SAMPLE_W-1:0] black,
      input logic [p2r_pkg::SAMPLE_W-1:0] mx);
    logic [63:0] prod;
    logic [63:0] full;
    prod = 64'(chan) * 64'(black);
    full = 64'(mx) * 64'(mx);
    if (prod >= full) return p2r_pkg::CHAN_FULL;
    return p2r_pkg::CHAN_W'((prod * 64'd510 + full) / (64'd2 * full));
  endfunction

  function automatic rgb_pixel_t convert_pixel(input logic [p2r_pkg::SAMPLE_W-1:0] s0,
                                               input logic [p2r_pkg::SAMPLE_W-1:0] s1,
                                               input logic [p2r_pkg::SAMPLE_W-1:0] s2,
                                               input logic [p2r_pkg::SAMPLE_W-1:0] s3,
                                               input logic row_end);
    rgb_pixel_t px;
    px         = '0;
    px.row_end = row_end;
    if (full_scale == '0) begin
      px.bad_format = 1'b1;
    end else begin
      case (comp_count)
        p2r_pkg::CC_GRAY: begin
          px.red   = scale_to_8bit(s0, full_scale);
          px.green = px.red;
          px.blue  = px.red;
        end
        p2r_pkg::CC_RGB: begin
          px.red   = scale_to_8bit(s0, full_scale);
          px.green = scale_to_8bit(s1, full_scale);
          px.blue  = scale_to_8bit(s2, full_scale);
        end
        p2r_pkg::CC_CMYK: begin
          px.red   = ink_to_8bit(s0, s3, full_scale);
          px.green = ink_to_8bit(s1, s3, full_scale);
          px.blue  = ink_to_8bit(s2, s3, full_scale);
        end
        default: px.bad_format = 1'b1;
      endcase
    end
    return px;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      full_scale = p2r_pkg::FULL_SCALE_RST;
      comp_count = p2r_pkg::COMP_COUNT_RST;
      pixels_due.delete();
    end else begin
      if (pix_out.valid && pix_out.ready) begin
        got_px = '{pix_out.red, pix_out.green, pix_out.blue,
                   pix_out.bad_format, pix_out.row_end_out};
        if (pixels_due.size() == 0) begin
          report_mismatch("result with no item pending", 1, 0);
        end else begin
          want_px = pixels_due.pop_front();
          if (got_px.red != want_px.red)
            report_mismatch("red", int'(got_px.red), int'(want_px.red));
          if (got_px.green != want_px.green)
            report_mismatch("green", int'(got_px.green), int'(want_px.green));
          if (got_px.blue != want_px.blue)
            report_mismatch("blue", int'(got_px.blue), int'(want_px.blue));
          if (got_px.bad_format != want_px.bad_format)
            report_mismatch("bad_format", int'(got_px.bad_format),
                            int'(want_px.bad_format));
          if (got_px.row_end != want_px.row_end)
            report_mismatch("row_end_out", int'(got_px.row_end), int'(want_px.row_end));
        end
      end
      if (pix_in.valid && pix_in.ready)
        pixels_due.push_back(convert_pixel(pix_in.sample_0, pix_in.sample_1,
                                           pix_in.sample_2, pix_in.sample_3,
                                           pix_in.row_end_in));
      if (cfg_write_en) begin
        case (cfg_index)
          p2r_pkg::REG_FULL_SCALE: full_scale = cfg_data;
          p2r_pkg::REG_COMP_COUNT: comp_count = cfg_data[p2r_pkg::CC_W-1:0];
          default: ;
        endcase
      end
    end
    pending = pixels_due.size();
  end

endmodule

// File: sim/pixel_to_rgb888_converter_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_to_rgb888_converter_top_tb
// drives pixels through the converter under a series of formats and source
// precisions, with bursty input, a stalling output and long output hold-offs;
// the checker beside the block predicts every result and counts mismatches
// ----------------------------------------------------------------------------
module pixel_to_rgb888_converter_top_tb;

  localparam int CYCLE_LIMIT  = 200000;  // generous bound on the whole run
  localparam int DRAIN_CYCLES = 20;      // margin after the last pending result
  localparam int HOLD_CYCLES  = 80;      // long output hold-off, fills the pipe
  localparam int RANDOM_ITEMS = 420;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           cfg_write_en = 1'b0;
  logic [p2r_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [p2r_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  p2r_in_if  pix_in_ch ();
  p2r_out_if pix_out_ch ();

  int fail_count;
  int pending;

  // sender burst bookkeeping and the request for a long output hold-off
  int items_sent    = 0;
  int burst_left    = 0;
  bit long_hold_req = 1'b0;

  always #5 clk = ~clk;

  pixel_to_rgb888_converter_top dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .pix_in       (pix_in_ch),
    .pix_out      (pix_out_ch)
  );

  p2r_pixel_checker pixel_check (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .pix_in       (pix_in_ch),
    .pix_out      (pix_out_ch),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  // offer one item at a falling edge and hold it until the block takes it;
  // a new burst starts after a random gap with valid low, which may be empty
  task automatic send_pixel(input logic [p2r_pkg::SAMPLE_W-1:0] s0,
                            input logic [p2r_pkg::SAMPLE_W-1:0] s1,
                            input logic [p2r_pkg::SAMPLE_W-1:0] s2,
                            input logic [p2r_pkg::SAMPLE_W-1:0] s3,
                            input logic row_end);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        pix_in_ch.valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    pix_in_ch.valid      = 1'b1;
    pix_in_ch.sample_0   = s0;
    pix_in_ch.sample_1   = s1;
    pix_in_ch.sample_2   = s2;
    pix_in_ch.sample_3   = s3;
    pix_in_ch.row_end_in = row_end;
    // ready is sampled at the rising edge, before the block updates
    @(posedge clk);
    while (!pix_in_ch.ready) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  // stop offering and let every pending result come out before touching config
  task automatic wait_idle();
    pix_in_ch.valid = 1'b0;
    burst_left      = 0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [p2r_pkg::CFG_IDX_W-1:0]  idx,
                           input logic [p2r_pkg::CFG_DATA_W-1:0] val);
    cfg_write_en = 1'b1;
    cfg_index    = idx;
    cfg_data     = val;
    @(negedge clk);
    cfg_write_en = 1'b0;
  endtask

  task automatic set_format(input logic [p2r_pkg::SAMPLE_W-1:0] mx,
                            input logic [p2r_pkg::CC_W-1:0] cc);
    wait_idle();
    write_reg(p2r_pkg::REG_FULL_SCALE, mx);
    write_reg(p2r_pkg::REG_COMP_COUNT, p2r_pkg::CFG_DATA_W'(cc));
  endtask

  // random sample: full-width noise, zero, in range, and the edges around max
  function automatic logic [p2r_pkg::SAMPLE_W-1:0] pick_sample(
      input logic [p2r_pkg::SAMPLE_W-1:0] mx);
    case ($urandom_range(0, 6))
      0:       return p2r_pkg::SAMPLE_W'($urandom);
      1:       return '0;
      2:       return p2r_pkg::SAMPLE_W'($urandom_range(0, mx));
      3:       return mx;
      4:       return mx - 1'b1;
      5:       return mx + 1'b1;
      default: return p2r_pkg::SAMPLE_W'($urandom_range(0, mx));
    endcase
  endfunction

  // cycle limit: a hang anywhere ends the run as a failure
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("timeout after %0d cycles, %0d items still pending", CYCLE_LIMIT, pending);
    $display("Simulation FAILED");
    $finish;
  end

  // receiver: stretches of always ready, coin flip, mostly stalled and mostly
  // ready, plus a long hold-off as soon as the stimulus asks for one
  initial begin
    int mode;
    int span;
    pix_out_ch.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (long_hold_req) begin
        long_hold_req    = 1'b0;
        pix_out_ch.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      mode = $urandom_range(0, 3);
      span = $urandom_range(5, 40);
      repeat (span) begin
        if (long_hold_req) break;
        case (mode)
          0:       pix_out_ch.ready = 1'b1;
          1:       pix_out_ch.ready = $urandom_range(0, 1);
          2:       pix_out_ch.ready = ($urandom_range(0, 7) == 0);
          default: pix_out_ch.ready = ($urandom_range(0, 3) != 0);
        endcase
        @(negedge clk);
      end
    end
  end

  // stimulus and verdict
  initial begin
    int phase;
    int n_items;
    logic [p2r_pkg::SAMPLE_W-1:0] mx;
    logic [p2r_pkg::CC_W-1:0]     cc;
    logic [p2r_pkg::SAMPLE_W-1:0] blk;

    pix_in_ch.valid      = 1'b0;
    pix_in_ch.sample_0   = '0;
    pix_in_ch.sample_1   = '0;
    pix_in_ch.sample_2   = '0;
    pix_in_ch.sample_3   = '0;
    pix_in_ch.row_end_in = 1'b0;

    rst = 1'b1;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset format: rgb at 8 bits, zero, full and above-max samples
    send_pixel(16'd0, 16'd255, 16'd128, 16'd7, 1'b0);
    send_pixel(16'hFFFF, 16'd254, 16'd256, 16'd0, 1'b1);

    // gray: only sample_0 counts, the rest is junk
    set_format(16'd255, p2r_pkg::CC_GRAY);
    send_pixel(16'd200, 16'hFFFF, 16'hAAAA, 16'h5555, 1'b1);
    send_pixel(16'hFFFF, 16'd0, 16'd0, 16'd0, 1'b0);

    // max 2 makes exact halves: ties round up
    set_format(16'd2, p2r_pkg::CC_RGB);
    send_pixel(16'd1, 16'd2, 16'd3, 16'hFFFF, 1'b0);
    set_format(16'd2, p2r_pkg::CC_CMYK);
    send_pixel(16'd1, 16'd2, 16'd0, 16'd2, 1'b1);
    send_pixel(16'd2, 16'd2, 16'd2, 16'd0, 1'b0);

    // full 16-bit precision, products right at the clamp
    set_format(16'hFFFF, p2r_pkg::CC_CMYK);
    send_pixel(16'hFFFF, 16'hFFFE, 16'h8000, 16'hFFFF, 1'b1);
    send_pixel(16'h5555, 16'hAAAA, 16'h1234, 16'h8000, 1'b0);
    set_format(16'hFFFF, p2r_pkg::CC_GRAY);
    send_pixel(16'h8000, 16'h0001, 16'h0002, 16'h0003, 1'b1);

    // one-bit precision
    set_format(16'd1, p2r_pkg::CC_RGB);
    send_pixel(16'd0, 16'd1, 16'd2, 16'd0, 1'b0);

    // zero full scale is an invalid format whatever the count
    set_format(16'd0, p2r_pkg::CC_RGB);
    send_pixel(16'd5, 16'd5, 16'd5, 16'd5, 1'b1);

    // every invalid component count
    set_format(16'd255, 3'd0);
    send_pixel(16'd100, 16'd100, 16'd100, 16'd100, 1'b0);
    set_format(16'd255, 3'd2);
    send_pixel(16'd100, 16'd200, 16'd50, 16'd255, 1'b1);
    set_format(16'd255, 3'd5);
    send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
    set_format(16'd255, 3'd6);
    send_pixel(16'd1, 16'd2, 16'd3, 16'd4, 1'b1);
    set_format(16'd255, 3'd7);
    send_pixel(16'd9, 16'd8, 16'd7, 16'd6, 1'b0);

    // random phases: mostly valid formats at common and odd precisions
    items_sent = 0;
    phase      = 0;
    while (items_sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 7))
        0:       mx = 16'd1;
        1:       mx = 16'd2;
        2:       mx = 16'd255;
        3:       mx = 16'd4095;
        4:       mx = 16'hFFFF;
        5:       mx = 16'd1023;
        6:       mx = p2r_pkg::SAMPLE_W'($urandom_range(1, 65535));
        default: mx = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'd255;
      endcase
      case ($urandom_range(0, 9))
        0, 1, 2: cc = p2r_pkg::CC_RGB;
        3, 4, 5: cc = p2r_pkg::CC_CMYK;
        6, 7:    cc = p2r_pkg::CC_GRAY;
        default: cc = p2r_pkg::CC_W'($urandom_range(0, 7));
      endcase
      set_format(mx, cc);
      n_items = $urandom_range(15, 50);
      // a couple of phases run back to back against a long output hold-off
      if (phase == 2 || phase == 6) begin
        long_hold_req = 1'b1;
        burst_left    = n_items;
      end
      repeat (n_items) begin
        // black mostly near full so cmyk values spread over the range
        blk = ($urandom_range(0, 2) == 0) ? pick_sample(mx)
                                          : mx - p2r_pkg::SAMPLE_W'($urandom_range(0, 3));
        send_pixel(pick_sample(mx), pick_sample(mx), pick_sample(mx), blk,
                   1'($urandom_range(0, 1)));
      end
      phase++;
    end

    wait_idle();
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      if (pending != 0) $display("%0d items never produced a result", pending);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
design/p2r_pkg.sv
design/p2r_in_if.sv
design/p2r_out_if.sv
design/p2r_front.sv
design/p2r_div_stage.sv
design/pixel_to_rgb888_converter_top.sv
sim/p2r_pixel_checker.sv
sim/pixel_to_rgb888_converter_top_tb.sv
